FILE: rtl/core/gn2d_pkg.sv
// Shared types and constants for the 2D gradient noise pipeline.
// Used by gn2d_hash, gn2d_fade, gn2d_blend and gradient_noise_2d; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package gn2d_pkg;

    // Formats fixed by the field widths of the stream.
    localparam int FRAC_BITS  = 16;                 // fraction bits of a coordinate
    localparam int TABLE_SIZE = 256;                // permutation table entries
    localparam int TAB_AW     = $clog2(TABLE_SIZE); // table address bits
    localparam int BYTE_W     = 8;                  // table entry width
    localparam int COORD_W    = 24;                 // coordinate width
    localparam int GRAD_FRAC  = 7;                  // gradient component is (p-128)/128

    // Command codes carried in tuser.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    // Fade polynomial 6t^5 - 15t^4 + 10t^3 as t^3 * (6t^2 - 15t + 10).
    localparam int FADE_A = 6;
    localparam int FADE_B = 15;
    localparam int FADE_C = 10;
    localparam int POLY_W = FRAC_BITS + 4;          // poly stays below 11.0

    // Datapath widths.
    localparam int MUL_W  = BYTE_W + FRAC_BITS + 1;     // gradient times offset
    localparam int DOT_W  = MUL_W + 1;                  // sum of two products
    localparam int DIFF_W = DOT_W + 1;                  // b - a of a blend
    localparam int PROD_W = FRAC_BITS + 1 + DIFF_W;     // fade times difference
    localparam int RND_W  = DOT_W + 1;                  // value plus offset and half
    localparam int OUT_W  = 18;                         // noise_value width
    localparam int OUT_SHIFT = GRAD_FRAC + 1;           // drop to FRAC_BITS and halve
    localparam int TDATA_OUT_W = 24;                    // OUT_W padded to bytes

    // Adds 1.0 in Q.(FRAC_BITS+7) and a half unit of the final shift.
    localparam logic signed [RND_W-1:0] ROUND_ADD =
        RND_W'((64'd1 << (FRAC_BITS + GRAD_FRAC)) + (64'd1 << (OUT_SHIFT - 1)));

    typedef logic [FRAC_BITS-1:0] t_frac;
    typedef logic [TAB_AW-1:0]    t_tab_addr;
    typedef logic [BYTE_W-1:0]    t_byte;

    // Control that travels with each stage.
    typedef struct packed {
        logic valid;
        logic load;
    } t_ctl;

    // Two table bytes that form one corner gradient.
    typedef struct packed {
        t_byte gy;
        t_byte gx;
    } t_grad_pair;

endpackage

`default_nettype wire

FILE: rtl/core/gn2d_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module gn2d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/gn2d_hash.sv
// Corner hashing: three lookup stages over seven copies of the permutation table.
// Depends on gn2d_pkg and gn2d_ram.
`timescale 1ns / 1ps
`default_nettype none

module gn2d_hash (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire gn2d_pkg::t_ctl              i_ctl,
    input  wire gn2d_pkg::t_tab_addr         i_index,
    input  wire gn2d_pkg::t_byte             i_value,
    input  wire gn2d_pkg::t_tab_addr         i_xi,
    input  wire gn2d_pkg::t_tab_addr         i_yi,
    output logic                             o_valid,
    output gn2d_pkg::t_grad_pair [3:0]       o_grad
);

    gn2d_pkg::t_ctl      r_s1_ctl;
    gn2d_pkg::t_ctl      r_s2_ctl;
    logic                r_s3_valid;
    gn2d_pkg::t_tab_addr r_s1_index;
    gn2d_pkg::t_byte     r_s1_value;
    gn2d_pkg::t_tab_addr r_s1_yi;
    gn2d_pkg::t_tab_addr r_s2_index;
    gn2d_pkg::t_byte     r_s2_value;

    gn2d_pkg::t_byte     w_ax;
    gn2d_pkg::t_byte     w_bx;
    gn2d_pkg::t_byte     w_h [4];

    logic w_we0, w_re0, w_we1, w_re1, w_we2, w_re2;

    // A load writes each copy at the stage that reads it, so every item
    // sees exactly the loads that came before it.
    assign w_we0 = i_en & i_ctl.valid & i_ctl.load;
    assign w_re0 = i_en & i_ctl.valid & ~i_ctl.load;
    assign w_we1 = i_en & r_s1_ctl.valid & r_s1_ctl.load;
    assign w_re1 = i_en & r_s1_ctl.valid & ~r_s1_ctl.load;
    assign w_we2 = i_en & r_s2_ctl.valid & r_s2_ctl.load;
    assign w_re2 = i_en & r_s2_ctl.valid & ~r_s2_ctl.load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl   <= '0;
            r_s2_ctl   <= '0;
            r_s3_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_ctl   <= i_ctl;
            r_s2_ctl   <= r_s1_ctl;
            r_s3_valid <= r_s2_ctl.valid & ~r_s2_ctl.load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_index <= i_index;
            r_s1_value <= i_value;
            r_s1_yi    <= i_yi;
            r_s2_index <= r_s1_index;
            r_s2_value <= r_s1_value;
        end
    end

    // Stage 1 lookup: p[X] and p[X+1].
    gn2d_ram #(
        .WIDTH (gn2d_pkg::BYTE_W),
        .DEPTH (gn2d_pkg::TABLE_SIZE)
    ) u_copy_x (
        .i_clk     (i_clk),
        .i_we      (w_we0),
        .i_waddr   (i_index),
        .i_wdata   (i_value),
        .i_re      (w_re0),
        .i_raddr_a (i_xi),
        .i_raddr_b (gn2d_pkg::TAB_AW'(i_xi + gn2d_pkg::TAB_AW'(1))),
        .o_rdata_a (w_ax),
        .o_rdata_b (w_bx)
    );

    // Stage 2 lookups: the four corner hashes, row y and row y+1.
    gn2d_ram #(
        .WIDTH (gn2d_pkg::BYTE_W),
        .DEPTH (gn2d_pkg::TABLE_SIZE)
    ) u_copy_y0 (
        .i_clk     (i_clk),
        .i_we      (w_we1),
        .i_waddr   (r_s1_index),
        .i_wdata   (r_s1_value),
        .i_re      (w_re1),
        .i_raddr_a (gn2d_pkg::TAB_AW'(w_ax + r_s1_yi)),
        .i_raddr_b (gn2d_pkg::TAB_AW'(w_bx + r_s1_yi)),
        .o_rdata_a (w_h[0]),
        .o_rdata_b (w_h[1])
    );

    gn2d_ram #(
        .WIDTH (gn2d_pkg::BYTE_W),
        .DEPTH (gn2d_pkg::TABLE_SIZE)
    ) u_copy_y1 (
        .i_clk     (i_clk),
        .i_we      (w_we1),
        .i_waddr   (r_s1_index),
        .i_wdata   (r_s1_value),
        .i_re      (w_re1),
        .i_raddr_a (gn2d_pkg::TAB_AW'(w_ax + r_s1_yi + gn2d_pkg::TAB_AW'(1))),
        .i_raddr_b (gn2d_pkg::TAB_AW'(w_bx + r_s1_yi + gn2d_pkg::TAB_AW'(1))),
        .o_rdata_a (w_h[2]),
        .o_rdata_b (w_h[3])
    );

    // Stage 3 lookups: gradient bytes p[h] and p[h+1], one copy per corner.
    for (genvar k = 0; k < 4; k++) begin : g_corner
        gn2d_ram #(
            .WIDTH (gn2d_pkg::BYTE_W),
            .DEPTH (gn2d_pkg::TABLE_SIZE)
        ) u_copy_g (
            .i_clk     (i_clk),
            .i_we      (w_we2),
            .i_waddr   (r_s2_index),
            .i_wdata   (r_s2_value),
            .i_re      (w_re2),
            .i_raddr_a (w_h[k]),
            .i_raddr_b (gn2d_pkg::TAB_AW'(w_h[k] + gn2d_pkg::TAB_AW'(1))),
            .o_rdata_a (o_grad[k].gx),
            .o_rdata_b (o_grad[k].gy)
        );
    end

    assign o_valid = r_s3_valid;

endmodule

`default_nettype wire

FILE: rtl/core/gn2d_fade.sv
// Fade curve 6t^5-15t^4+10t^3 for both fractions, three multiply stages.
// Depends on gn2d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gn2d_fade (
    input  wire logic                   i_clk,
    input  wire logic                   i_en,
    input  wire gn2d_pkg::t_frac [1:0]  i_t,
    output gn2d_pkg::t_frac [1:0]       o_t,
    output gn2d_pkg::t_frac [1:0]       o_f
);

    localparam int FB = gn2d_pkg::FRAC_BITS;
    localparam int PW = gn2d_pkg::POLY_W;

    for (genvar k = 0; k < 2; k++) begin : g_lane
        gn2d_pkg::t_frac r1_t, r1_t2;
        gn2d_pkg::t_frac r2_t, r2_t3;
        logic [PW-1:0]   r2_poly;
        gn2d_pkg::t_frac r3_t, r3_f;

        logic [2*FB-1:0] w_sq;
        logic [2*FB-1:0] w_cube;
        logic [PW-1:0]   w_poly;
        logic [FB+PW-1:0] w_prod;

        assign w_sq   = (2*FB)'(i_t[k]) * (2*FB)'(i_t[k]);
        assign w_cube = (2*FB)'(r1_t2) * (2*FB)'(r1_t);
        // Always positive on [0,1): the polynomial falls from 10 to 1.
        assign w_poly = PW'(gn2d_pkg::FADE_A) * PW'(r1_t2)
                      + (PW'(gn2d_pkg::FADE_C) << FB)
                      - PW'(gn2d_pkg::FADE_B) * PW'(r1_t);
        assign w_prod = (FB+PW)'(r2_t3) * (FB+PW)'(r2_poly);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r1_t    <= i_t[k];
                r1_t2   <= w_sq[2*FB-1:FB];
                r2_t    <= r1_t;
                r2_t3   <= w_cube[2*FB-1:FB];
                r2_poly <= w_poly;
                r3_t    <= r2_t;
                // Fade stays below 1.0, so the top bits are zero.
                r3_f    <= w_prod[2*FB-1:FB];
            end
        end

        assign o_t[k] = r3_t;
        assign o_f[k] = r3_f;
    end

endmodule

`default_nettype wire

FILE: rtl/core/gn2d_blend.sv
// Corner dot products, two bilinear blend levels and the final offset and scale.
// Depends on gn2d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gn2d_blend (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire gn2d_pkg::t_grad_pair [3:0]    i_grad,
    input  wire gn2d_pkg::t_frac [1:0]         i_t,
    input  wire gn2d_pkg::t_frac [1:0]         i_f,
    output logic                               o_valid,
    output logic signed [gn2d_pkg::OUT_W-1:0]  o_noise
);

    localparam int FB     = gn2d_pkg::FRAC_BITS;
    localparam int MUL_W  = gn2d_pkg::MUL_W;
    localparam int DOT_W  = gn2d_pkg::DOT_W;
    localparam int DIFF_W = gn2d_pkg::DIFF_W;
    localparam int PROD_W = gn2d_pkg::PROD_W;
    localparam int RND_W  = gn2d_pkg::RND_W;
    localparam int NSTG   = 8;     // stages 4 through 11

    logic [NSTG-1:0] r_vld;

    logic signed [DOT_W-1:0]  r4_dot [4];
    gn2d_pkg::t_frac [1:0]    r4_f;
    logic signed [DOT_W-1:0]  r5_a [2];
    logic signed [DIFF_W-1:0] r5_d [2];
    gn2d_pkg::t_frac [1:0]    r5_f;
    logic signed [DOT_W-1:0]  r6_a [2];
    logic signed [PROD_W-1:0] r6_p [2];
    gn2d_pkg::t_frac          r6_fy;
    logic signed [DOT_W-1:0]  r7_r [2];
    gn2d_pkg::t_frac          r7_fy;
    logic signed [DOT_W-1:0]  r8_a;
    logic signed [DIFF_W-1:0] r8_d;
    gn2d_pkg::t_frac          r8_fy;
    logic signed [DOT_W-1:0]  r9_a;
    logic signed [PROD_W-1:0] r9_p;
    logic signed [DOT_W-1:0]  r10_v;
    logic signed [gn2d_pkg::OUT_W-1:0] r11_out;

    logic signed [DOT_W-1:0]  w_dot [4];
    logic signed [RND_W-1:0]  w_rnd;

    // Corner k: bit 0 selects x+1, bit 1 selects y+1.
    for (genvar k = 0; k < 4; k++) begin : g_dot
        localparam bit XHI = (k % 2) == 1;
        localparam bit YHI = (k / 2) == 1;
        logic signed [FB:0]                 w_dx, w_dy;
        logic signed [gn2d_pkg::BYTE_W-1:0] w_gx, w_gy;
        logic signed [MUL_W-1:0]            w_px, w_py;

        // Offset t-1 is t with the sign bit set.
        assign w_dx = $signed({XHI, i_t[0]});
        assign w_dy = $signed({YHI, i_t[1]});
        // p - 128 is p with the top bit inverted.
        assign w_gx = $signed({~i_grad[k].gx[gn2d_pkg::BYTE_W-1],
                               i_grad[k].gx[gn2d_pkg::BYTE_W-2:0]});
        assign w_gy = $signed({~i_grad[k].gy[gn2d_pkg::BYTE_W-1],
                               i_grad[k].gy[gn2d_pkg::BYTE_W-2:0]});
        assign w_px = MUL_W'(w_gx) * MUL_W'(w_dx);
        assign w_py = MUL_W'(w_gy) * MUL_W'(w_dy);
        assign w_dot[k] = DOT_W'(w_px) + DOT_W'(w_py);
    end

    assign w_rnd = RND_W'(r10_v) + gn2d_pkg::ROUND_ADD;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 4; k++) begin
                r4_dot[k] <= w_dot[k];
            end
            r4_f <= i_f;
            // First level: blend along x on both rows.
            for (int j = 0; j < 2; j++) begin
                r5_a[j] <= r4_dot[2*j];
                r5_d[j] <= DIFF_W'(r4_dot[2*j+1]) - DIFF_W'(r4_dot[2*j]);
                r6_a[j] <= r5_a[j];
                r6_p[j] <= PROD_W'($signed({1'b0, r5_f[0]})) * PROD_W'(r5_d[j]);
                r7_r[j] <= r6_a[j] + DOT_W'(r6_p[j] >>> FB);
            end
            r5_f  <= r4_f;
            r6_fy <= r5_f[1];
            r7_fy <= r6_fy;
            // Second level: blend the rows along y.
            r8_a  <= r7_r[0];
            r8_d  <= DIFF_W'(r7_r[1]) - DIFF_W'(r7_r[0]);
            r8_fy <= r7_fy;
            r9_a  <= r8_a;
            r9_p  <= PROD_W'($signed({1'b0, r8_fy})) * PROD_W'(r8_d);
            r10_v <= r9_a + DOT_W'(r9_p >>> FB);
            // Add 1.0 and a half, then halve and drop to FRAC_BITS.
            r11_out <= w_rnd[gn2d_pkg::OUT_SHIFT +: gn2d_pkg::OUT_W];
        end
    end

    assign o_valid = r_vld[NSTG-1];
    assign o_noise = r11_out;

endmodule

`default_nettype wire

FILE: rtl/core/gradient_noise_2d.sv
// Throughput: one transaction per cycle while no result is held at the output;
// loads and evaluates mixed freely; the 14 table lookups per point are served by
// seven table copies with two read ports each.
// A load writes each copy as it passes that copy's stage and yields no result.
// Reset (i_rst_n low, synchronous) clears every stage valid bit; the table stays
// undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module gradient_noise_2d (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input stream.
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [63:0] i_s_tdata,  // table_index[7:0], table_value[15:8],
                                         // x_coord[39:16], y_coord[63:40]
    input  wire logic        i_s_tuser,  // command (0 load, 1 evaluate)
    // Result stream.
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata   // noise_value[17:0], zero pad [23:18]
);

    localparam int FB = gn2d_pkg::FRAC_BITS;
    localparam int CW = gn2d_pkg::COORD_W;

    // Stage 0: the registered input transaction.
    logic                       r_s0_valid;
    logic                       r_s0_load;
    gn2d_pkg::t_tab_addr        r_s0_index;
    gn2d_pkg::t_byte            r_s0_value;
    logic [CW-1:0]              r_s0_x;
    logic [CW-1:0]              r_s0_y;

    logic                       w_en;
    gn2d_pkg::t_ctl             w_s0_ctl;
    logic                       w_hash_valid;
    gn2d_pkg::t_grad_pair [3:0] w_grad;
    gn2d_pkg::t_frac [1:0]      w_t;
    gn2d_pkg::t_frac [1:0]      w_f;
    logic                       w_out_valid;
    logic signed [gn2d_pkg::OUT_W-1:0] w_noise;

    // Advance the whole pipeline unless a finished result is held at the output.
    assign w_en       = ~w_out_valid | i_m_tready;
    assign o_s_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s0_load  <= 1'b0;
        end else if (w_en) begin
            r_s0_valid <= i_s_tvalid;
            r_s0_load  <= (i_s_tuser == gn2d_pkg::CMD_LOAD);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_index <= i_s_tdata[7:0];
            r_s0_value <= i_s_tdata[15:8];
            r_s0_x     <= i_s_tdata[39:16];
            r_s0_y     <= i_s_tdata[63:40];
        end
    end

    assign w_s0_ctl.valid = r_s0_valid;
    assign w_s0_ctl.load  = r_s0_load;

    // Stages 1-3: cell corner hashing and gradient byte lookup.
    gn2d_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_s0_ctl),
        .i_index (r_s0_index),
        .i_value (r_s0_value),
        // Integer parts mod TABLE_SIZE are the low integer bits.
        .i_xi    (r_s0_x[FB +: gn2d_pkg::TAB_AW]),
        .i_yi    (r_s0_y[FB +: gn2d_pkg::TAB_AW]),
        .o_valid (w_hash_valid),
        .o_grad  (w_grad)
    );

    // Stages 1-3 in parallel: fade of both fractions, aligned with the lookups.
    gn2d_fade u_fade (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_t   ({r_s0_y[FB-1:0], r_s0_x[FB-1:0]}),
        .o_t   (w_t),
        .o_f   (w_f)
    );

    // Stages 4-11: dot products, blends and the output register.
    gn2d_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_hash_valid),
        .i_grad  (w_grad),
        .i_t     (w_t),
        .i_f     (w_f),
        .o_valid (w_out_valid),
        .o_noise (w_noise)
    );

    assign o_m_tvalid = w_out_valid;
    assign o_m_tdata  = {{(gn2d_pkg::TDATA_OUT_W - gn2d_pkg::OUT_W){1'b0}}, w_noise};

    // Reset empties the pipeline by the next edge.
    a_rst_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // An accepted evaluate transaction lands in stage 0 as an evaluate.
    a_eval_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tuser == gn2d_pkg::CMD_EVAL)
        |=> (r_s0_valid && !r_s0_load))
        else $error("accepted evaluate lost at stage 0");

    // A stalled pipeline holds its entry stage.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> ($stable(r_s0_valid) && $stable(r_s0_x) && $stable(r_s0_y)))
        else $error("stage 0 changed during a stall");

endmodule

`default_nettype wire
